@@ sv/kpc_pkg.sv @@
// kpc_pkg: shared types and constants for the knob position conditioner.
// Holds the controller states, the command and status structs, and register indexes.
// No dependencies.
`default_nettype none

package kpc_pkg;

	localparam int MV_W   = 16;            // millivolt fields
	localparam int PM_W   = 10;            // per mille fields
	localparam int PROD_W = 26;            // product range used (offset*1000 < 2^26)
	localparam int ROOT_W = 20;            // radicand range (pos*1000 <= 1e6 < 2^20)
	localparam int IDX_W  = 3;             // config register index
	localparam int STEP_W = 4;             // iteration counter

	localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(9);   // 10 quotient bits
	localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(9);   // 10 root bits

	localparam logic [PM_W-1:0]   PM_FULL    = 10'd1000;
	localparam logic [PM_W-1:0]   DETENT_LO  = 10'd480;
	localparam logic [PM_W-1:0]   DETENT_HI  = 10'd520;
	localparam logic [PM_W-1:0]   DETENT_MID = 10'd500;
	localparam logic [PM_W-1:0]   SNAP_LO    = 10'd10;
	localparam logic [PM_W-1:0]   SNAP_HI    = 10'd990;
	localparam logic [MV_W-1:0]   DEFAULT_FS = 16'd3300;
	localparam logic [ROOT_W-1:0] ROOT_TOP   = ROOT_W'(1) << 18;
	localparam logic [PM_W-1:0]   HYST_RESET = 10'd10;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_WINDOW_MIN = 3'd0;
	localparam logic [IDX_W-1:0] REG_WINDOW_MAX = 3'd1;
	localparam logic [IDX_W-1:0] REG_FULL_SCALE = 3'd2;
	localparam logic [IDX_W-1:0] REG_TAPER      = 3'd3;
	localparam logic [IDX_W-1:0] REG_INVERT     = 3'd4;
	localparam logic [IDX_W-1:0] REG_HYST       = 3'd5;

	typedef enum logic [1:0] {
		TAPER_STD    = 2'd0,
		TAPER_DETENT = 2'd1,
		TAPER_LOG    = 2'd2,
		TAPER_ALOG   = 2'd3
	} taper_t;

	typedef enum logic [1:0] {
		MUL_OFFSET_K = 2'd0,   // clamped offset * 1000
		MUL_POS_K    = 2'd1,   // position * 1000
		MUL_POS_SQ   = 2'd2    // position * position
	} mul_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_DIV_INIT,
		S_DIV,
		S_POS,
		S_TAPER,
		S_SQRT_INIT,
		S_SQRT,
		S_ROOT,
		S_FINISH,
		S_OUT
	} state_t;

	typedef struct packed {
		logic     load;        // capture the input beat
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     div_init;
		logic     div_k;       // divisor is 1000 instead of the window span
		logic     div_step;
		logic     pos_zero;
		logic     pos_quo;
		logic     sqrt_init;
		logic     sqrt_step;
		logic     pos_root;
		logic     finish;
	} cmd_t;

	typedef struct packed {
		logic   err;
		logic   empty;
		taper_t taper;
	} stat_t;

endpackage

`default_nettype wire

@@ sv/kpc_sample_if.sv @@
// kpc_sample_if: input channel of the knob position conditioner.
// One beat carries one millivolt sample and its read-error flag. No dependencies.
`default_nettype none

interface kpc_sample_if;
	logic        valid;
	logic        ready;
	logic [15:0] sample_mv;
	logic        read_error;

	modport source (output valid, output sample_mv, output read_error, input ready);
	modport sink   (input valid, input sample_mv, input read_error, output ready);
endinterface

`default_nettype wire

@@ sv/kpc_result_if.sv @@
// kpc_result_if: output channel of the knob position conditioner.
// One beat carries position, changed flag and status. No dependencies.
`default_nettype none

interface kpc_result_if;
	logic       valid;
	logic       ready;
	logic [9:0] position_promille;
	logic       changed;
	logic       status;

	modport source (output valid, output position_promille, output changed,
		output status, input ready);
	modport sink   (input valid, input position_promille, input changed,
		input status, output ready);
endinterface

`default_nettype wire

@@ sv/kpc_ctrl.sv @@
// kpc_ctrl: sequencer of the knob position conditioner.
// Drives the datapath through cmd_t and reads stat_t; uses kpc_pkg.
`default_nettype none

module kpc_ctrl
	import kpc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	logic              second_q, second_d;   // running the x*x/1000 division

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			second_q <= second_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		second_d  = second_q;
		cmd       = '0;
		cmd.mul_sel = MUL_OFFSET_K;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					second_d = 1'b0;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.err) begin
					state_d = S_FINISH;
				end else if (stat.empty) begin
					cmd.pos_zero = 1'b1;
					state_d      = S_TAPER;
				end else begin
					cmd.mul_en  = 1'b1;
					cmd.mul_sel = MUL_OFFSET_K;
					state_d     = S_DIV_INIT;
				end
			end
			S_DIV_INIT: begin
				cmd.div_init = 1'b1;
				cmd.div_k    = second_q;
				cnt_d        = '0;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = S_POS;
				end
			end
			S_POS: begin
				cmd.pos_quo = 1'b1;
				state_d     = second_q ? S_FINISH : S_TAPER;
			end
			S_TAPER: begin
				case (stat.taper)
					TAPER_LOG: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = MUL_POS_K;
						state_d     = S_SQRT_INIT;
					end
					TAPER_ALOG: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = MUL_POS_SQ;
						second_d    = 1'b1;
						state_d     = S_DIV_INIT;
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_SQRT_INIT: begin
				cmd.sqrt_init = 1'b1;
				cnt_d         = '0;
				state_d       = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == ROOT_LAST) begin
					state_d = S_ROOT;
				end
			end
			S_ROOT: begin
				cmd.pos_root = 1'b1;
				state_d      = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ sv/kpc_datapath.sv @@
// kpc_datapath: config registers, shared multiplier, restoring divider,
// bit-pair square root, finishing logic and baseline. Uses kpc_pkg.
`default_nettype none

module kpc_datapath
	import kpc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [MV_W-1:0]  cfg_data,
	input  wire logic [MV_W-1:0]  sample_mv,
	input  wire logic             read_error,
	input  wire cmd_t             cmd,
	output stat_t                 stat,
	output logic [PM_W-1:0]       position_promille,
	output logic                  changed,
	output logic                  status
);

	// configuration
	logic [MV_W-1:0] win_min_q, win_max_q, full_scale_q;
	taper_t          taper_q;
	logic            invert_q;
	logic [PM_W-1:0] hyst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_min_q    <= '0;
			win_max_q    <= '0;
			full_scale_q <= DEFAULT_FS;
			taper_q      <= TAPER_STD;
			invert_q     <= 1'b0;
			hyst_q       <= HYST_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_MIN: win_min_q    <= cfg_data;
				REG_WINDOW_MAX: win_max_q    <= cfg_data;
				REG_FULL_SCALE: full_scale_q <= cfg_data;
				REG_TAPER:      taper_q      <= taper_t'(cfg_data[1:0]);
				REG_INVERT:     invert_q     <= cfg_data[0];
				REG_HYST:       hyst_q       <= cfg_data[PM_W-1:0];
				default: ;
			endcase
		end
	end

	// captured beat
	logic [MV_W-1:0] mv_q;
	logic            err_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mv_q  <= sample_mv;
			err_q <= read_error;
		end
	end

	// window
	logic [MV_W-1:0] lo, hi, clamped, offset, span;

	always_comb begin
		lo = win_min_q;
		hi = win_max_q;
		if (win_min_q == '0 && win_max_q == '0) begin
			hi = (full_scale_q != '0) ? full_scale_q : DEFAULT_FS;
		end
		clamped = mv_q;
		if (clamped < lo) clamped = lo;
		if (clamped > hi) clamped = hi;
		offset = clamped - lo;
		span   = hi - lo;
	end

	assign stat.err   = err_q;
	assign stat.empty = (lo >= hi);
	assign stat.taper = taper_q;

	// shared multiplier, registered
	logic [PM_W-1:0]   pos_q;
	logic [MV_W-1:0]   mul_a, mul_b;
	logic [PROD_W-1:0] mul_q;

	always_comb begin
		case (cmd.mul_sel)
			MUL_POS_K: begin
				mul_a = MV_W'(pos_q);
				mul_b = MV_W'(PM_FULL);
			end
			MUL_POS_SQ: begin
				mul_a = MV_W'(pos_q);
				mul_b = MV_W'(pos_q);
			end
			default: begin
				mul_a = offset;
				mul_b = MV_W'(PM_FULL);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			mul_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
	end

	// restoring divider: quotient < 1024, so the top bits start the remainder
	logic [MV_W-1:0] rem_q, dvs_q;
	logic [PM_W-1:0] quo_q;          // low dividend bits shift out, quotient bits in
	logic [MV_W:0]   trial;
	logic            q_bit;

	assign trial = {rem_q, quo_q[PM_W-1]};
	assign q_bit = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= mul_q[PROD_W-1:PM_W];
			quo_q <= mul_q[PM_W-1:0];
			dvs_q <= cmd.div_k ? MV_W'(PM_FULL) : span;
		end else if (cmd.div_step) begin
			rem_q <= q_bit ? MV_W'(trial - {1'b0, dvs_q}) : trial[MV_W-1:0];
			quo_q <= {quo_q[PM_W-2:0], q_bit};
		end
	end

	// bit-pair integer square root
	logic [ROOT_W-1:0] rad_q, root_q, rbit_q;
	logic [ROOT_W:0]   rtrial;
	logic              r_take;

	assign rtrial = {1'b0, root_q} + {1'b0, rbit_q};
	assign r_take = ({1'b0, rad_q} >= rtrial);

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			rad_q  <= mul_q[ROOT_W-1:0];
			root_q <= '0;
			rbit_q <= ROOT_TOP;
		end else if (cmd.sqrt_step) begin
			if (r_take) begin
				rad_q  <= ROOT_W'({1'b0, rad_q} - rtrial);
				root_q <= (root_q >> 1) + rbit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			rbit_q <= rbit_q >> 2;
		end
	end

	// working position
	always_ff @(posedge clk) begin
		if (cmd.pos_zero) begin
			pos_q <= '0;
		end else if (cmd.pos_quo) begin
			pos_q <= (quo_q > PM_FULL) ? PM_FULL : quo_q;
		end else if (cmd.pos_root) begin
			pos_q <= (root_q > ROOT_W'(PM_FULL)) ? PM_FULL : root_q[PM_W-1:0];
		end
	end

	// detent, inversion, snaps, hysteresis
	logic [PM_W-1:0] detent, inv, cur, diff;
	logic            moved;
	logic [PM_W-1:0] base_q;

	always_comb begin
		detent = pos_q;
		if (taper_q == TAPER_DETENT && pos_q >= DETENT_LO && pos_q <= DETENT_HI) begin
			detent = DETENT_MID;
		end
		inv = invert_q ? PM_FULL - detent : detent;
		if (inv <= SNAP_LO) begin
			cur = '0;
		end else if (inv >= SNAP_HI) begin
			cur = PM_FULL;
		end else begin
			cur = inv;
		end
		diff  = (cur >= base_q) ? cur - base_q : base_q - cur;
		moved = (diff >= hyst_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cmd.finish && !err_q && moved) begin
			base_q <= cur;
		end
	end

	logic [PM_W-1:0] res_pos_q;
	logic            res_changed_q, res_status_q;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (err_q) begin
				res_pos_q     <= base_q;
				res_changed_q <= 1'b0;
				res_status_q  <= 1'b1;
			end else begin
				res_pos_q     <= moved ? cur : base_q;
				res_changed_q <= moved;
				res_status_q  <= 1'b0;
			end
		end
	end

	assign position_promille = res_pos_q;
	assign changed           = res_changed_q;
	assign status            = res_status_q;

endmodule

`default_nettype wire

@@ sv/knob_position_conditioner.sv @@
// knob_position_conditioner: top level; ties the sequencer to the datapath.
// Depends on kpc_pkg, kpc_sample_if, kpc_result_if, kpc_ctrl, kpc_datapath.
//
// Usage
//   sample_in  : valid/ready beat of one millivolt sample plus read_error.
//   result_out : valid/ready beat of position_promille, changed, status;
//                exactly one result beat per sample beat, in order.
//   cfg_*      : write-only port, register index 0..5 in the order
//                window min, window max, full scale, taper, invert, hysteresis.
//                Write only while no sample is in flight.
// Sequence (one item at a time; sample_in.ready is high only when idle)
//   read error          :  check, then finish with status set
//   empty window        :  position 0, then the taper step as below
//   standard / detent   : scale divide, then finish
//   logarithmic         : scale divide plus 10-step root
//   anti-logarithmic    : scale divide plus second 10-step divide by 1000
//   The restoring divider and the square root each run 10 steps;
//   after the result handshake the sequencer returns to idle.
// Reset: config returns to its defaults (full scale 3300, hysteresis 10),
//   the baseline clears to 0, no result is pending.
// Stall: the result holds on result_out until ready; no new sample is taken
//   until it has been delivered.
`default_nettype none

module knob_position_conditioner
	import kpc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [MV_W-1:0]  cfg_data,
	kpc_sample_if.sink            sample_in,
	kpc_result_if.source          result_out
);

	cmd_t  cmd;     // sequencer -> datapath
	stat_t stat;    // datapath -> sequencer

	kpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_in.valid),
		.in_ready  (sample_in.ready),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	kpc_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.sample_mv         (sample_in.sample_mv),
		.read_error        (sample_in.read_error),
		.cmd               (cmd),
		.stat              (stat),
		.position_promille (result_out.position_promille),
		.changed           (result_out.changed),
		.status            (result_out.status)
	);

endmodule

`default_nettype wire
